/* src/spr_pkg.sv */
// Shared types, codes and constants of the serial packet receiver.
`default_nettype none

package spr_pkg;

   // Port widths
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 8;

   // Default depth of the queue between parser and formatter
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_START = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACK   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NAK   = 2'd2;

   // Configuration reset values
   localparam logic [7:0] START_RESET = 8'd92;
   localparam logic [7:0] ACK_RESET   = 8'd6;
   localparam logic [7:0] NAK_RESET   = 8'd21;

   // Input word kinds
   localparam logic ACT_BYTE    = 1'b0;
   localparam logic ACT_TIMEOUT = 1'b1;

   // First payload bytes that select a command kind
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUERY = 8'h3F;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_TYPE  = 3'd1,
      PH_COUNT = 3'd2,
      PH_DATA  = 3'd3,
      PH_CKSUM = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      EV_DATA     = 3'd0,
      EV_ACK      = 3'd1,
      EV_NAK      = 3'd2,
      EV_ACCEPT   = 3'd3,
      EV_BAD_SUM  = 3'd4,
      EV_TIMEOUT  = 3'd5
   } event_type;

   typedef enum logic [2:0] {
      KIND_IMAGE    = 3'd0,
      KIND_END_SCAN = 3'd1,
      KIND_IDENTIFY = 3'd2,
      KIND_SCAN_ERR = 3'd3,
      KIND_OTHER    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      REPLY_NONE = 2'd0,
      REPLY_ACK  = 2'd1,
      REPLY_NAK  = 2'd2,
      REPLY_ETX  = 2'd3
   } reply_type;

   // Classified event handed from parser to formatter
   typedef struct packed {
      event_type   ev;
      logic [7:0]  data;    // data byte, or first payload byte of an accepted frame
      logic [7:0]  second;  // second payload byte
      logic [15:0] len;     // payload bytes received
      logic        type7;   // command frame
      logic        type5;   // compressed
   } rec_type;

endpackage

`default_nettype wire

/* src/spr_front.sv */
// Frame parser: accepts link words, tracks frame state, emits classified events.
`default_nettype none

module spr_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [spr_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [spr_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [spr_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire logic [spr_pkg::REQ_TUSER_W-1:0]      req_tuser,
   input  wire logic                                 queue_full,
   output logic                                      push_valid,
   output spr_pkg::rec_type                          push_rec
);

   spr_pkg::phase_type phase_ff, phase_in;
   logic        started_ff, started_in;
   logic [7:0]  start_ff, ack_ff, nak_ff;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sum_ff, sum_in;
   logic        seen_ff, seen_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic        accept;
   logic [7:0]  rx;
   logic [15:0] count_next;
   logic [7:0]  expect_sum;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign rx         = req_tdata[7:0];
   assign count_next = {remaining_ff[7:0], rx};
   assign expect_sum = 8'd0 - sum_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= spr_pkg::START_RESET;
         ack_ff   <= spr_pkg::ACK_RESET;
         nak_ff   <= spr_pkg::NAK_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            spr_pkg::CSR_START: start_ff <= csr_wdata;
            spr_pkg::CSR_ACK:   ack_ff   <= csr_wdata;
            spr_pkg::CSR_NAK:   nak_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= spr_pkg::PH_IDLE;
         started_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         started_ff <= started_in;
      end
   end

   // Hold frame payload state
   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      sum_ff       <= sum_in;
      seen_ff      <= seen_in;
      remaining_ff <= remaining_in;
      rlen_ff      <= rlen_in;
      first_ff     <= first_in;
      second_ff    <= second_in;
   end

   // Advance the parser and classify the word
   always_comb begin
      phase_in        = phase_ff;
      started_in      = started_ff;
      type_in         = type_ff;
      sum_in          = sum_ff;
      seen_in         = seen_ff;
      remaining_in    = remaining_ff;
      rlen_in         = rlen_ff;
      first_in        = first_ff;
      second_in       = second_ff;
      push_valid      = 1'b0;
      push_rec.ev     = spr_pkg::EV_DATA;
      push_rec.data   = rx;
      push_rec.second = second_ff;
      push_rec.len    = rlen_ff;
      push_rec.type7  = type_ff[7];
      push_rec.type5  = type_ff[5];

      if (accept) begin
         if (req_tuser[0] == spr_pkg::ACT_TIMEOUT) begin
            // Abort only once a count byte has been seen
            if (started_ff) begin
               phase_in    = spr_pkg::PH_IDLE;
               started_in  = 1'b0;
               push_valid  = 1'b1;
               push_rec.ev = spr_pkg::EV_TIMEOUT;
            end
         end else begin
            unique case (phase_ff)
               spr_pkg::PH_TYPE: begin
                  type_in      = rx;
                  sum_in       = rx;
                  seen_in      = 1'b0;
                  remaining_in = 16'd0;
                  phase_in     = spr_pkg::PH_COUNT;
               end
               spr_pkg::PH_COUNT: begin
                  sum_in       = sum_ff + rx;
                  remaining_in = count_next;
                  started_in   = 1'b1;
                  if (seen_ff) begin
                     rlen_in  = 16'd0;
                     phase_in = (count_next == 16'd0) ? spr_pkg::PH_CKSUM
                                                      : spr_pkg::PH_DATA;
                  end else begin
                     seen_in = 1'b1;
                  end
               end
               spr_pkg::PH_DATA: begin
                  if (rlen_ff == 16'd0) begin
                     first_in = rx;
                  end else if (rlen_ff == 16'd1) begin
                     second_in = rx;
                  end
                  rlen_in      = rlen_ff + 16'd1;
                  sum_in       = sum_ff + rx;
                  remaining_in = remaining_ff - 16'd1;
                  if (remaining_ff == 16'd1) begin
                     phase_in = spr_pkg::PH_CKSUM;
                  end
                  push_valid = 1'b1;
               end
               spr_pkg::PH_CKSUM: begin
                  phase_in   = spr_pkg::PH_IDLE;
                  started_in = 1'b0;
                  push_valid = 1'b1;
                  if (expect_sum != rx) begin
                     push_rec.ev = spr_pkg::EV_BAD_SUM;
                  end else begin
                     push_rec.ev   = spr_pkg::EV_ACCEPT;
                     push_rec.data = first_ff;
                  end
               end
               default: begin
                  // Idle: acknowledge tests come before the start test
                  phase_in = spr_pkg::PH_IDLE;
                  if (rx == ack_ff) begin
                     push_valid  = 1'b1;
                     push_rec.ev = spr_pkg::EV_ACK;
                  end else if (rx == nak_ff) begin
                     push_valid  = 1'b1;
                     push_rec.ev = spr_pkg::EV_NAK;
                  end else begin
                     sum_in = 8'd0;
                     if (rx == start_ff) begin
                        phase_in = spr_pkg::PH_TYPE;
                     end
                  end
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

/* src/spr_queue.sv */
// Short event queue between parser and result formatter.
`default_nettype none

module spr_queue #(
   parameter int DEPTH = spr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  spr_pkg::rec_type      push_rec,
   output logic                  full,
   input  wire logic             pop,
   output spr_pkg::rec_type      head_rec,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   spr_pkg::rec_type   entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_valid && !full;
   assign head_rec = entries_ff[rd_ptr_ff];

   // Store pushed events
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_rec;
      end
   end

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* src/spr_back.sv */
// Result formatter: decodes frame kind, commit length and reply into the output register.
`default_nettype none

module spr_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  spr_pkg::rec_type                       head_rec,
   input  wire logic                              empty,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [spr_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic [spr_pkg::RSP_TUSER_W-1:0]        rsp_tuser
);

   logic                              valid_ff, valid_in;
   logic [spr_pkg::RSP_TDATA_W-1:0]   tdata_ff, tdata_in;
   logic [spr_pkg::RSP_TUSER_W-1:0]   tuser_ff, tuser_in;
   logic                              load;
   spr_pkg::kind_type                 kind;
   spr_pkg::kind_type                 kind_res;
   spr_pkg::reply_type                reply;
   logic [7:0]                        data_byte;
   logic                              comp;
   logic [15:0]                       commit_len;
   logic [7:0]                        err_code;
   logic                              is_accept;

   assign load       = !empty && (!valid_ff || rsp_tready);
   assign pop        = load;
   assign is_accept  = (head_rec.ev == spr_pkg::EV_ACCEPT);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tuser  = tuser_ff;

   // Decode the frame kind from the type byte and first payload byte
   always_comb begin
      if (!head_rec.type7) begin
         kind = spr_pkg::KIND_IMAGE;
      end else if (head_rec.len == 16'd0) begin
         kind = spr_pkg::KIND_OTHER;
      end else begin
         unique case (head_rec.data)
            spr_pkg::CH_D:     kind = spr_pkg::KIND_IMAGE;
            spr_pkg::CH_E:     kind = spr_pkg::KIND_END_SCAN;
            spr_pkg::CH_BANG:  kind = spr_pkg::KIND_IDENTIFY;
            spr_pkg::CH_QUERY: kind = spr_pkg::KIND_SCAN_ERR;
            default:           kind = spr_pkg::KIND_OTHER;
         endcase
      end
   end

   // Build the result fields; frame-end fields stay zero for other events
   always_comb begin
      data_byte  = 8'd0;
      kind_res   = spr_pkg::KIND_IMAGE;
      comp       = 1'b0;
      commit_len = 16'd0;
      err_code   = 8'd0;
      reply      = spr_pkg::REPLY_NONE;
      unique case (head_rec.ev)
         spr_pkg::EV_DATA: begin
            data_byte = head_rec.data;
         end
         spr_pkg::EV_BAD_SUM, spr_pkg::EV_TIMEOUT: begin
            reply = spr_pkg::REPLY_NAK;
         end
         default: ;
      endcase
      if (is_accept) begin
         kind_res   = kind;
         comp       = head_rec.type5;
         commit_len = head_rec.len;
         if (kind == spr_pkg::KIND_IMAGE && !head_rec.type5) begin
            commit_len = {head_rec.len[15:2], 2'b00};
         end
         if (kind == spr_pkg::KIND_SCAN_ERR && head_rec.len >= 16'd2) begin
            err_code = head_rec.second;
         end
         if (kind == spr_pkg::KIND_END_SCAN || kind == spr_pkg::KIND_SCAN_ERR) begin
            reply = spr_pkg::REPLY_ETX;
         end else begin
            reply = spr_pkg::REPLY_ACK;
         end
      end
   end

   // Load the output register when it is free or being drained
   always_comb begin
      valid_in = valid_ff;
      tdata_in = tdata_ff;
      tuser_in = tuser_ff;
      if (load) begin
         valid_in = 1'b1;
         tdata_in = {2'b00, reply, err_code, commit_len, comp, kind_res, data_byte};
         tuser_in = head_rec.ev;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tdata_ff <= tdata_in;
      tuser_ff <= tuser_in;
   end

endmodule

`default_nettype wire

/* src/serial_packet_receiver.sv */
// Top level of the serial packet receiver: parser, event queue and formatter.
// Each result passes through the event queue, then the output register, onto rsp.
// Throughput: one word per clock unless the queue is full; each steps the parser.
// req_tready drops only when the event queue is full; the output register drains it.
// Reset (synchronous): parser returns to idle, queue and output empty, start/ack/nak
// bytes return to 92, 6 and 21.
`default_nettype none

module serial_packet_receiver #(
   parameter int QUEUE_DEPTH = spr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [spr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [spr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [spr_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [7:0] rx_byte
   input  wire logic [spr_pkg::REQ_TUSER_W-1:0]   req_tuser,  // [0] action
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] data_byte, [10:8] packet_kind, [11] compressed, [27:12] commit_length,
   // [35:28] error_code, [37:36] reply, [39:38] zero
   output logic [spr_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic [spr_pkg::RSP_TUSER_W-1:0]        rsp_tuser   // [2:0] event_res
);

   logic             queue_full;
   logic             queue_empty;
   logic             push_valid;
   logic             pop;
   spr_pkg::rec_type push_rec;
   spr_pkg::rec_type head_rec;

   spr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_rec   (push_rec)
   );

   spr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .full       (queue_full),
      .pop        (pop),
      .head_rec   (head_rec),
      .empty      (queue_empty)
   );

   spr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_rec   (head_rec),
      .empty      (queue_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* src/spr_checker.sv */
// Port-level checks of the serial packet receiver, bound to the top level.
`default_nettype none

module spr_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [spr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire logic [spr_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   // Output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // Data byte is zero on every non-data word
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != spr_pkg::EV_DATA |-> rsp_tdata[7:0] == 8'd0)
      else $error("data byte set on non-data word");

   // Aborted or bad frames reply NAK, with the kind, compressed, length and error fields zero
   a_reply_nak: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == spr_pkg::EV_BAD_SUM || rsp_tuser == spr_pkg::EV_TIMEOUT)
      |-> rsp_tdata[37:36] == spr_pkg::REPLY_NAK && rsp_tdata[35:8] == 28'd0)
      else $error("reject word has wrong reply or fields");

   // Accepted frame replies ETX exactly for end-of-scan and error kinds
   a_reply_etx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == spr_pkg::EV_ACCEPT
      |-> (rsp_tdata[37:36] == spr_pkg::REPLY_ETX)
          == (rsp_tdata[10:8] == spr_pkg::KIND_END_SCAN
              || rsp_tdata[10:8] == spr_pkg::KIND_SCAN_ERR))
      else $error("reply does not match packet kind");

endmodule

bind serial_packet_receiver spr_checker u_checker (.*);

`default_nettype wire
